FILE: sv/nap_pkg.sv
// nap_pkg: shared types, constants and palette rom functions for the
// nearest palette colour block; no dependencies

package nap_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int CH_W            = 8;
    localparam int IDX_W           = 8;
    localparam int DIST_W          = 22;
    localparam int SQ_W            = 2 * CH_W;
    localparam int WEIGHT_W        = 10;

    localparam logic [IDX_W-1:0]    PAL_LAST   = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [IDX_W-1:0]    CUBE_BASE  = IDX_W'(16);
    localparam logic [IDX_W-1:0]    GRAY_BASE  = IDX_W'(232);
    localparam logic [CH_W-1:0]     GRAY_START = CH_W'(8);
    localparam logic [CH_W-1:0]     CHROMA_MIN = CH_W'(8);
    localparam logic [2:0]          DIGIT_LAST = 3'd5;
    localparam logic [WEIGHT_W-1:0] RED_BASE   = WEIGHT_W'(512);
    localparam logic [WEIGHT_W-1:0] BLUE_BASE  = WEIGHT_W'(767);
    localparam logic [DIST_W-1:0]   DIST_EMPTY = '1;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    // one palette address issued by the sequencer, with cube digits
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [2:0]       cr;
        logic [2:0]       cg;
        logic [2:0]       cb;
    } t_addr;

    // one scored palette entry from the distance unit
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic              gray;
        logic [DIST_W-1:0] score;
    } t_cand;

    // running best entries of the scan
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_i;
        logic [DIST_W-1:0] gray_d;
        logic [IDX_W-1:0]  gray_i;
        logic [DIST_W-1:0] col_d;
        logic [IDX_W-1:0]  col_i;
    } t_best;

    function automatic t_rgb sys_color(input logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = '{8'd0,   8'd0,   8'd0};
            4'd1:    c = '{8'd128, 8'd0,   8'd0};
            4'd2:    c = '{8'd0,   8'd128, 8'd0};
            4'd3:    c = '{8'd128, 8'd128, 8'd0};
            4'd4:    c = '{8'd0,   8'd0,   8'd128};
            4'd5:    c = '{8'd128, 8'd0,   8'd128};
            4'd6:    c = '{8'd0,   8'd128, 8'd128};
            4'd7:    c = '{8'd192, 8'd192, 8'd192};
            4'd8:    c = '{8'd128, 8'd128, 8'd128};
            4'd9:    c = '{8'd255, 8'd0,   8'd0};
            4'd10:   c = '{8'd0,   8'd255, 8'd0};
            4'd11:   c = '{8'd255, 8'd255, 8'd0};
            4'd12:   c = '{8'd0,   8'd0,   8'd255};
            4'd13:   c = '{8'd255, 8'd0,   8'd255};
            4'd14:   c = '{8'd0,   8'd255, 8'd255};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    function automatic logic [CH_W-1:0] cube_level(input logic [2:0] d);
        logic [CH_W-1:0] v;
        case (d)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd95;
            3'd2:    v = 8'd135;
            3'd3:    v = 8'd175;
            3'd4:    v = 8'd215;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // palette colour of an address; cube digits come from the sequencer
    function automatic t_rgb palette_color(input t_addr a);
        t_rgb            c;
        logic [IDX_W-1:0] k;
        logic [CH_W-1:0] lvl;
        k   = a.idx - GRAY_BASE;
        lvl = GRAY_START + CH_W'({k, 3'b000}) + CH_W'({k, 1'b0});
        if (a.idx < CUBE_BASE) begin
            c = sys_color(a.idx[3:0]);
        end else if (a.idx < GRAY_BASE) begin
            c = '{cube_level(a.cr), cube_level(a.cg), cube_level(a.cb)};
        end else begin
            c = '{lvl, lvl, lvl};
        end
        return c;
    endfunction

endpackage

FILE: sv/nap_dist.sv
// nap_dist: two-stage redmean distance unit with the palette rom
// depends on nap_pkg

module nap_dist
    import nap_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_rgb  i_pix,
    input  t_addr i_addr,
    output t_cand o_cand
);

    t_rgb              w_ent;
    logic [CH_W-1:0]   w_dr, w_dg, w_db;
    logic [CH_W:0]     w_rsum;

    logic              r_a_vld, r_a_last, r_a_gray;
    logic [IDX_W-1:0]  r_a_idx;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [CH_W-1:0]   r_rm;

    logic [WEIGHT_W+SQ_W-1:0] w_wr, w_wb;
    logic [DIST_W-1:0]        w_dist;
    t_cand                    r_cand;

    // stage a: rom lookup, channel differences and squares
    always_comb begin
        w_ent  = palette_color(i_addr);
        w_dr   = (i_pix.r > w_ent.r) ? i_pix.r - w_ent.r : w_ent.r - i_pix.r;
        w_dg   = (i_pix.g > w_ent.g) ? i_pix.g - w_ent.g : w_ent.g - i_pix.g;
        w_db   = (i_pix.b > w_ent.b) ? i_pix.b - w_ent.b : w_ent.b - i_pix.b;
        w_rsum = {1'b0, i_pix.r} + {1'b0, w_ent.r};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_addr.vld;
        end
        r_a_last <= i_addr.last;
        r_a_idx  <= i_addr.idx;
        r_a_gray <= (i_addr.idx >= GRAY_BASE) ||
                    ((w_ent.r == w_ent.g) && (w_ent.g == w_ent.b));
        r_sq_r   <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g   <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b   <= SQ_W'(w_db) * SQ_W'(w_db);
        r_rm     <= w_rsum[CH_W:1];
    end

    // stage b: weighting by the red mean and sum
    always_comb begin
        w_wr   = (WEIGHT_W+SQ_W)'(RED_BASE + WEIGHT_W'(r_rm)) * (WEIGHT_W+SQ_W)'(r_sq_r);
        w_wb   = (WEIGHT_W+SQ_W)'(BLUE_BASE - WEIGHT_W'(r_rm)) * (WEIGHT_W+SQ_W)'(r_sq_b);
        w_dist = DIST_W'(w_wr[WEIGHT_W+SQ_W-1:8]) + DIST_W'({r_sq_g, 2'b00})
               + DIST_W'(w_wb[WEIGHT_W+SQ_W-1:8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.vld <= 1'b0;
        end else begin
            r_cand.vld <= r_a_vld;
        end
        r_cand.last  <= r_a_last;
        r_cand.idx   <= r_a_idx;
        r_cand.gray  <= r_a_gray;
        r_cand.score <= w_dist;
    end

    assign o_cand = r_cand;

endmodule

FILE: sv/nap_track.sv
// nap_track: keeps the exact hit and the best gray and colour entries
// depends on nap_pkg

module nap_track
    import nap_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  t_cand i_cand,
    output t_best o_best
);

    t_best r_best, n_best;

    always_comb begin
        n_best = r_best;
        if (i_clear) begin
            n_best.hit    = 1'b0;
            n_best.hit_i  = '0;
            n_best.gray_d = DIST_EMPTY;
            n_best.gray_i = '0;
            n_best.col_d  = DIST_EMPTY;
            n_best.col_i  = '0;
        end else if (i_cand.vld) begin
            // zero distance only for an identical colour; first one is lowest index
            if (i_cand.score == '0 && !r_best.hit) begin
                n_best.hit   = 1'b1;
                n_best.hit_i = i_cand.idx;
            end
            if (i_cand.gray) begin
                if (i_cand.score < r_best.gray_d) begin
                    n_best.gray_d = i_cand.score;
                    n_best.gray_i = i_cand.idx;
                end
            end else if (i_cand.score < r_best.col_d) begin
                n_best.col_d = i_cand.score;
                n_best.col_i = i_cand.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.hit <= 1'b0;
        end else begin
            r_best.hit <= n_best.hit;
        end
        r_best.hit_i  <= n_best.hit_i;
        r_best.gray_d <= n_best.gray_d;
        r_best.gray_i <= n_best.gray_i;
        r_best.col_d  <= n_best.col_d;
        r_best.col_i  <= n_best.col_i;
    end

    assign o_best = r_best;

endmodule

FILE: sv/nearest_ansi_palette_color.sv
// nearest_ansi_palette_color: top level, scan sequencer, final choice and output register
// depends on nap_pkg, nap_dist, nap_track
//
// channel  | dir | tdata fields (lowest bit first)                     | note
// s_axis   | in  | red[7:0] green[15:8] blue[23:16] highest_index[31:24] | colour to match
// m_axis   | out | palette_index[7:0] exact_hit[8], zero pad [15:9]     | one per input
//
// an input transfer starts a scan of palette entries 0 to the clamped limit;
// each entry passes distance stages a and b and then the tracker, and the
// decision state loads the result into the output register once that is
// free; one palette entry goes through the shared distance unit per cycle
// while the scan runs
// reset is synchronous, active low, and empties the pipeline and the output
// s_axis_tready is high only while no scan runs; a finished result waits in
// the output register and the next input may already be taken meanwhile

module nearest_ansi_palette_color
    import nap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // red, green, blue, highest_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // palette_index, exact_hit, zero pad
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_rgb             r_pix;
    logic [IDX_W-1:0] r_lim, r_idx;
    logic [2:0]       r_cr, r_cg, r_cb;

    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_hit;

    logic             w_in_xfer, w_out_free, w_load;
    logic [IDX_W-1:0] w_in_lim;
    t_addr            w_addr;
    t_cand            w_cand;
    t_best            w_best;

    logic [CH_W-1:0]  w_mx, w_mn;
    logic             w_chroma, w_take_gray;
    logic [IDX_W-1:0] w_pick;
    logic [DIST_W+1:0] w_gray3;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_load        = (r_state == S_DECIDE) && w_out_free;

    // limit beyond the rom is clamped to the last entry
    assign w_in_lim = ({1'b0, s_axis_tdata[31:24]} > {1'b0, PAL_LAST}) ?
                      PAL_LAST : s_axis_tdata[31:24];

    // address issued to the distance unit, one entry per scan cycle
    always_comb begin
        w_addr.vld  = (r_state == S_SCAN);
        w_addr.last = (r_idx == r_lim);
        w_addr.idx  = r_idx;
        w_addr.cr   = r_cr;
        w_addr.cg   = r_cg;
        w_addr.cb   = r_cb;
    end

    nap_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (r_pix),
        .i_addr  (w_addr),
        .o_cand  (w_cand)
    );

    nap_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_in_xfer),
        .i_cand  (w_cand),
        .o_best  (w_best)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_addr.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // tracker takes the last entry at this edge
                if (w_cand.vld && w_cand.last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan index and cube digits; digits step from the cube base onward
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pix <= '{s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
            r_lim <= w_in_lim;
            r_idx <= '0;
            r_cr  <= '0;
            r_cg  <= '0;
            r_cb  <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + IDX_W'(1);
            if (r_idx >= CUBE_BASE) begin
                if (r_cb == DIGIT_LAST) begin
                    r_cb <= '0;
                    if (r_cg == DIGIT_LAST) begin
                        r_cg <= '0;
                        r_cr <= r_cr + 3'd1;
                    end else begin
                        r_cg <= r_cg + 3'd1;
                    end
                end else begin
                    r_cb <= r_cb + 3'd1;
                end
            end
        end
    end

    // chromatic test and the choice between the gray and colour winners; an exact hit wins
    always_comb begin
        w_mx = r_pix.r;
        w_mn = r_pix.r;
        if (r_pix.g > w_mx) w_mx = r_pix.g;
        if (r_pix.b > w_mx) w_mx = r_pix.b;
        if (r_pix.g < w_mn) w_mn = r_pix.g;
        if (r_pix.b < w_mn) w_mn = r_pix.b;
        w_chroma = (w_mx > CHROMA_MIN) && ((w_mx - w_mn) > {2'b00, w_mx[CH_W-1:2]});
        w_gray3  = {1'b0, w_best.gray_d, 1'b0} + {2'b00, w_best.gray_d};
        if (w_chroma) begin
            w_take_gray = w_gray3 < {2'b00, w_best.col_d};
        end else begin
            w_take_gray = w_best.gray_d <= w_best.col_d;
        end
        if (w_best.hit) begin
            w_pick = w_best.hit_i;
        end else if (w_take_gray) begin
            w_pick = w_best.gray_i;
        end else begin
            w_pick = w_best.col_i;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_load) begin
            r_out_idx <= w_pick;
            r_out_hit <= w_best.hit;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out_hit, r_out_idx};

    // an accepted transfer always starts a scan
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == S_SCAN)
        else $error("scan did not start after input transfer");

    // the distance pipeline is empty whenever the block is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_cand.vld)
        else $error("scored entry while idle");

    // an exact hit never lies beyond the limit
    a_hit_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_best.hit |-> w_best.hit_i <= r_lim)
        else $error("exact hit above the limit");

endmodule
